// ----- src/ilid_pkg.sv -----
// shared types and constants for the indexed list insert and dump block
package ilid_pkg;

   localparam int unsigned CAPACITY = 32;
   localparam int unsigned ADDR_W   = $clog2(CAPACITY);
   localparam int unsigned LEN_W    = 6;
   localparam int unsigned DATA_W   = 32;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_DUMP,
      ST_STATUS
   } seq_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

   typedef struct packed {
      logic       valid;
      logic       direction;
      status_type status;
      logic       last;
   } rsp_meta_type;

endpackage

// ----- src/ilid_mem.sv -----
// entry storage: one write port, one read port with registered read data
module ilid_mem (
   input  logic                                clock,
   input  ilid_pkg::mem_ctl_type               ctl,
   output logic [ilid_pkg::DATA_W-1:0]         rd_data
);

   logic [ilid_pkg::DATA_W-1:0] entries_ff [ilid_pkg::CAPACITY];
   logic [ilid_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entries_ff[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= entries_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ilid_seq.sv -----
// sequencer: shift loop, insert, two-way dump and result metadata register
module ilid_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ilid_pkg::LEN_W-1:0]         req_position,
   input  logic signed [ilid_pkg::DATA_W-1:0] req_value,
   input  logic                               rsp_ready,
   input  logic [ilid_pkg::DATA_W-1:0]        rd_data,
   output ilid_pkg::mem_ctl_type              mem_ctl,
   output ilid_pkg::rsp_meta_type             meta
);

   ilid_pkg::seq_state_type state_ff, state_in;
   logic [ilid_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [ilid_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [ilid_pkg::LEN_W-1:0]  idx_ff, idx_in;
   logic [ilid_pkg::DATA_W-1:0] val_ff, val_in;
   logic                        dir_ff, dir_in;
   ilid_pkg::status_type        stat_ff, stat_in;
   ilid_pkg::rsp_meta_type      meta_ff, meta_in;

   logic [ilid_pkg::LEN_W-1:0] idx_m1;
   logic                       issue;
   logic                       full;
   logic                       bad_pos;

   assign idx_m1  = idx_ff - ilid_pkg::LEN_W'(1);
   assign issue   = !meta_ff.valid || rsp_ready;
   assign full    = (len_ff == ilid_pkg::LEN_W'(ilid_pkg::CAPACITY));
   assign bad_pos = (req_position > len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ilid_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (full || bad_pos) begin
                  state_in = ilid_pkg::ST_STATUS;
               end else if (req_position == len_ff) begin
                  state_in = ilid_pkg::ST_INSERT;
               end else begin
                  state_in = ilid_pkg::ST_SHIFT_RD;
               end
            end
         end
         ilid_pkg::ST_SHIFT_RD: begin
            // the read register also feeds a response that may still wait
            if (issue) begin
               state_in = ilid_pkg::ST_SHIFT_WR;
            end
         end
         ilid_pkg::ST_SHIFT_WR: begin
            if (idx_m1 == pos_ff) begin
               state_in = ilid_pkg::ST_INSERT;
            end else begin
               state_in = ilid_pkg::ST_SHIFT_RD;
            end
         end
         ilid_pkg::ST_INSERT: begin
            state_in = ilid_pkg::ST_DUMP;
         end
         ilid_pkg::ST_DUMP: begin
            if (issue && dir_ff && (idx_ff == '0)) begin
               state_in = ilid_pkg::ST_IDLE;
            end
         end
         ilid_pkg::ST_STATUS: begin
            if (issue) begin
               state_in = ilid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ilid_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = (state_ff == ilid_pkg::ST_IDLE);
      len_in    = len_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      dir_in    = dir_ff;
      stat_in   = stat_ff;
      meta_in   = meta_ff;
      if (meta_ff.valid && rsp_ready) begin
         meta_in.valid = 1'b0;
      end
      mem_ctl         = '0;
      mem_ctl.wr_data = val_ff;

      unique case (state_ff)
         ilid_pkg::ST_IDLE: begin
            if (req_valid) begin
               pos_in  = req_position;
               val_in  = req_value;
               idx_in  = len_ff;
               stat_in = full ? ilid_pkg::STAT_FULL : ilid_pkg::STAT_INVALID;
            end
         end
         ilid_pkg::ST_SHIFT_RD: begin
            if (issue) begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = idx_m1[ilid_pkg::ADDR_W-1:0];
            end
         end
         ilid_pkg::ST_SHIFT_WR: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = idx_ff[ilid_pkg::ADDR_W-1:0];
            mem_ctl.wr_data = rd_data;
            idx_in          = idx_m1;
         end
         ilid_pkg::ST_INSERT: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = pos_ff[ilid_pkg::ADDR_W-1:0];
            mem_ctl.wr_data = val_ff;
            len_in          = len_ff + ilid_pkg::LEN_W'(1);
            idx_in          = '0;
            dir_in          = 1'b0;
         end
         ilid_pkg::ST_DUMP: begin
            if (issue) begin
               mem_ctl.rd_en     = 1'b1;
               mem_ctl.rd_addr   = idx_ff[ilid_pkg::ADDR_W-1:0];
               meta_in.valid     = 1'b1;
               meta_in.direction = dir_ff;
               meta_in.status    = ilid_pkg::STAT_OK;
               meta_in.last      = dir_ff && (idx_ff == '0);
               if (!dir_ff) begin
                  // forward pass ends at the top entry, reverse starts there
                  if (idx_ff == (len_ff - ilid_pkg::LEN_W'(1))) begin
                     dir_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + ilid_pkg::LEN_W'(1);
                  end
               end else if (idx_ff != '0) begin
                  idx_in = idx_m1;
               end
            end
         end
         ilid_pkg::ST_STATUS: begin
            if (issue) begin
               meta_in.valid     = 1'b1;
               meta_in.direction = 1'b0;
               meta_in.status    = stat_ff;
               meta_in.last      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ilid_pkg::ST_IDLE;
         len_ff   <= '0;
         meta_ff  <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         meta_ff  <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      dir_ff  <= dir_in;
      stat_ff <= stat_in;
   end

   assign meta = meta_ff;

endmodule

// ----- src/indexed_list_insert_dump_core.sv -----
// top level of the indexed list insert and dump block
//
// Keeps an ordered list of up to 32 signed 32-bit values, empty after reset.
// Each request transaction carries a position and a value; when the position
// is at most the current length the value is inserted there, later entries
// move up one place, and the block returns every entry first to last
// (direction 0) and then last to first (direction 1), with last set on the
// final response. A position past the length gives one response with status
// invalid; a request to a full list gives one response with status full; in
// both cases nothing is stored and element reads zero. Entries live in a
// single-port-write, single-port-read memory, so the shift loop moves each
// entry with a read state and then a write state, from the last entry down
// to the insert position; after the insert, the dump issues one response
// per cycle while rsp_ready is high, 2*(n+1) responses in all for a list
// of length n before the insert (at most 64). req_ready is high only
// while the sequencer is idle; the response
// register lets a new request be taken while the final response still waits,
// but since the response element is the memory read register, shift reads
// of the new request wait until that response is taken.
module indexed_list_insert_dump_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [5:0]                         req_position,
   input  logic signed [31:0]                 req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_element,
   output logic                               rsp_direction,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);

   ilid_pkg::mem_ctl_type       mem_ctl;
   ilid_pkg::rsp_meta_type      meta;
   logic [ilid_pkg::DATA_W-1:0] rd_data;

   // sequencer: owns the length, the shared index counter and the
   // response metadata register
   ilid_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_ready    (rsp_ready),
      .rd_data      (rd_data),
      .mem_ctl      (mem_ctl),
      .meta         (meta)
   );

   // entry store; read data is registered and holds until the next read
   ilid_mem u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_data (rd_data)
   );

   // response transaction: element comes straight from the read register,
   // forced to zero for status-only responses
   assign rsp_valid     = meta.valid;
   assign rsp_element   = (meta.status == ilid_pkg::STAT_OK) ? rd_data : '0;
   assign rsp_direction = meta.direction;
   assign rsp_status    = meta.status;
   assign rsp_last      = meta.last;

endmodule
